// File: sv/lfe_pkg.sv
package lfe_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 24;
    localparam int GAIN_FRAC       = 16;
    localparam int GAIN_W          = GAIN_FRAC + 1;
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_DATA_W      = 32;
    localparam int RESET_LENGTH    = 44100;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

    typedef enum logic [CFG_ADDR_W-3:0] {
        REG_LENGTH   = 2'd0,
        REG_FADE_IN  = 2'd1,
        REG_FADE_OUT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                 done;
        logic [GAIN_FRAC-1:0] quot;
    } div_resp_t;

    function automatic logic [GAIN_W-1:0] sat_frac(input logic [GAIN_W-1:0] f);
        return (f > GAIN_ONE) ? GAIN_ONE : f;
    endfunction

endpackage

// File: sv/lfe_div.sv
module lfe_div
    import lfe_pkg::*;
#(
    parameter int WIDTH = LENGTH_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output div_resp_t        resp
);

    localparam int CNT_W = $clog2(GAIN_FRAC);

    logic [WIDTH-1:0]     rem_reg;
    logic [WIDTH-1:0]     den_reg;
    logic [GAIN_FRAC-1:0] quot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;
    logic           ge;

    // The numerator is always below the divisor, so the quotient fits in the gain fraction.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num;
                den_reg  <= den;
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(GAIN_FRAC - 1);
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
                quot_reg <= {quot_reg[GAIN_FRAC-2:0], ge};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign resp.done = done_reg;
    assign resp.quot = quot_reg;

endmodule

// File: sv/lfe_mult.sv
module lfe_mult
    import lfe_pkg::*;
#(
    parameter int AW = LENGTH_BITS_DEF + 1,
    parameter int BW = GAIN_W + 1
) (
    input  logic                    aclk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= (AW+BW)'(a) * (AW+BW)'(b);
    end

endmodule

// File: sv/linear_fade_envelope.sv
// Channel   Ports                                   Direction
// config    psel penable pwrite paddr pwdata prdata  APB slave, pready tied high
// input     s_valid s_ready s_sample_in              beat in, one sample
// result    m_valid m_ready m_sample_out m_buffer_end beat out, one per sample
//
// One sample is worked on from one input beat to the next; its time is set by the shared
// serial divider, used once per gain, and the shared registered multiplier.
// The first sample of a buffer also passes through ST_LEN_A, ST_LEN_B and ST_LEN_C for the fade lengths.
// Reset is synchronous and active low; registers return to length 44100, no fades.
// A finished result waits in the output register while the next sample is taken.
module linear_fade_envelope
    import lfe_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_buffer_end
);

    localparam int MUL_A_W = ((SAMPLE_BITS > LENGTH_BITS) ? SAMPLE_BITS : LENGTH_BITS) + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN_A,
        ST_LEN_B,
        ST_LEN_C,
        ST_CHK_IN,
        ST_DIV_IN,
        ST_MUL_IN,
        ST_CAP_IN,
        ST_CHK_OUT,
        ST_DIV_OUT,
        ST_MUL_OUT,
        ST_CAP_OUT,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [LENGTH_BITS-1:0]  len_reg;
    logic [GAIN_W-1:0]       fin_frac_reg;
    logic [GAIN_W-1:0]       fout_frac_reg;
    logic [LENGTH_BITS-1:0]  pos_reg;
    logic [LENGTH_BITS-1:0]  fin_len_reg;
    logic [LENGTH_BITS-1:0]  fout_len_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic                    m_end_reg;
    logic                    m_valid_reg;

    logic                    cfg_wr;
    reg_idx_t                cfg_idx;
    logic [LENGTH_BITS-1:0]  eff_len;
    logic [LENGTH_BITS-1:0]  k_len;
    logic [LENGTH_BITS:0]    pos_inc;
    logic                    in_hit;
    logic                    out_hit;
    logic                    last;
    logic                    div_start;
    logic [LENGTH_BITS-1:0]  div_num;
    logic [LENGTH_BITS-1:0]  div_den;
    div_resp_t               div_resp;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= LENGTH_BITS'(RESET_LENGTH);
            fin_frac_reg  <= '0;
            fout_frac_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LENGTH:   len_reg       <= pwdata[LENGTH_BITS-1:0];
                REG_FADE_IN:  fin_frac_reg  <= pwdata[GAIN_W-1:0];
                REG_FADE_OUT: fout_frac_reg <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LENGTH:   prdata = CFG_DATA_W'(len_reg);
            REG_FADE_IN:  prdata = CFG_DATA_W'(fin_frac_reg);
            REG_FADE_OUT: prdata = CFG_DATA_W'(fout_frac_reg);
            default:      prdata = '0;
        endcase
    end

    assign eff_len = (len_reg == '0) ? LENGTH_BITS'(1) : len_reg;
    assign k_len   = eff_len - pos_reg;
    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign in_hit  = (pos_reg < fin_len_reg);
    assign out_hit = (pos_reg < eff_len) && (k_len <= fout_len_reg);
    assign last    = (pos_inc >= {1'b0, eff_len});

    assign div_start = ((state_reg == ST_CHK_IN) && in_hit) ||
                       ((state_reg == ST_CHK_OUT) && out_hit);
    assign div_num   = (state_reg == ST_CHK_IN) ? pos_reg : (k_len - 1'b1);
    assign div_den   = (state_reg == ST_CHK_IN) ? fin_len_reg : fout_len_reg;

    always_comb begin
        unique case (state_reg)
            ST_LEN_A: begin
                mul_a = $signed(MUL_A_W'(eff_len));
                mul_b = $signed(MUL_B_W'(sat_frac(fin_frac_reg)));
            end
            ST_LEN_B: begin
                mul_a = $signed(MUL_A_W'(eff_len));
                mul_b = $signed(MUL_B_W'(sat_frac(fout_frac_reg)));
            end
            ST_MUL_IN, ST_MUL_OUT: begin
                mul_a = MUL_A_W'(sample_reg);
                mul_b = $signed(MUL_B_W'(div_resp.quot));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lfe_div #(
        .WIDTH (LENGTH_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .resp    (div_resp)
    );

    lfe_mult #(
        .AW (MUL_A_W),
        .BW (MUL_B_W)
    ) u_mult (
        .aclk     (aclk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            fin_len_reg  <= '0;
            fout_len_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample_in;
                        state_reg  <= (pos_reg == '0) ? ST_LEN_A : ST_CHK_IN;
                    end
                end
                ST_LEN_A: state_reg <= ST_LEN_B;
                ST_LEN_B: begin
                    fin_len_reg <= prod[GAIN_FRAC +: LENGTH_BITS];
                    state_reg   <= ST_LEN_C;
                end
                ST_LEN_C: begin
                    fout_len_reg <= prod[GAIN_FRAC +: LENGTH_BITS];
                    state_reg    <= ST_CHK_IN;
                end
                ST_CHK_IN: state_reg <= in_hit ? ST_DIV_IN : ST_CHK_OUT;
                ST_DIV_IN: begin
                    if (div_resp.done) begin
                        state_reg <= ST_MUL_IN;
                    end
                end
                ST_MUL_IN: state_reg <= ST_CAP_IN;
                ST_CAP_IN: begin
                    sample_reg <= prod[GAIN_FRAC +: SAMPLE_BITS];
                    state_reg  <= ST_CHK_OUT;
                end
                ST_CHK_OUT: state_reg <= out_hit ? ST_DIV_OUT : ST_DONE;
                ST_DIV_OUT: begin
                    if (div_resp.done) begin
                        state_reg <= ST_MUL_OUT;
                    end
                end
                ST_MUL_OUT: state_reg <= ST_CAP_OUT;
                ST_CAP_OUT: begin
                    sample_reg <= prod[GAIN_FRAC +: SAMPLE_BITS];
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_sample_reg <= sample_reg;
                        m_end_reg    <= last;
                        m_valid_reg  <= 1'b1;
                        pos_reg      <= last ? '0 : pos_inc[LENGTH_BITS-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_buffer_end = m_end_reg;

endmodule

// File: sv/lfe_checker.sv
module lfe_checker
    import lfe_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input logic                          m_buffer_end
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_out) && $stable(m_buffer_end)))
        else $error("result beat changed while stalled");

    // One sample is worked on at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a beat");

    // A new result only appears while the block is busy.
    a_result_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    // A result does not rise straight after an input beat; the sequence runs through its states first.
    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!$rose(m_valid) ##1 !$rose(m_valid)))
        else $error("result came too soon after an input beat");

endmodule

bind linear_fade_envelope lfe_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lfe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out),
    .m_buffer_end (m_buffer_end)
);
